/* sv/bounded_ordered_list_engine_macros.svh */
// assertion helpers for the ordered list engine
`ifndef BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// property that holds on every clock edge out of reset
`define BOLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define BOLE_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BOLE_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BOLE_ASSERT(label, prop, msg)
`define BOLE_IMPLY(label, ante, cons, msg)
`define BOLE_NEXT(label, ante, cons, msg)

`endif

`endif

/* sv/bole_pkg.sv */
package bole_pkg;

  localparam int MODE_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int CAP_W       = 5;
  localparam int COUNT_OUT_W = 5;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_AFTER     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BEFORE    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEL_END   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEL_START = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEARCH = 6'b000010,
    ST_PREP   = 6'b000100,
    ST_EVICT  = 6'b001000,
    ST_SHIFT  = 6'b010000,
    ST_DELETE = 6'b100000
  } state_t;

endpackage

/* sv/bounded_ordered_list_engine.sv */
// channel    | ports                                      | transfer when
// -----------+--------------------------------------------+----------------------
// command    | start, busy, mode, key, value              | start high, busy low
// result     | done, status, entry_count, evicted_valid,  | done high (one cycle)
//            | evicted_value                              |
// capacity   | cfg_wr_en, cfg_wr_data                     | cfg_wr_en high
//
// one command at a time; busy is high while out of idle, until the edge that raises done
// an insert or delete on an empty list or an unused mode answers from idle; a delete reads
// its victim at the transfer; an insert after or before searches entries in order for the key,
// drops the first entry on overflow (the new value if it would be first), shifts the tail up
// to the insert place and writes; synchronous reset empties the list, sets capacity to ten,
// memory not cleared; the receiver cannot stall: done pulses for exactly one cycle
`include "bounded_ordered_list_engine_macros.svh"

module bounded_ordered_list_engine
  import bole_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [MODE_W-1:0]             mode,
  input  logic signed [DATA_WIDTH-1:0]  key,
  input  logic signed [DATA_WIDTH-1:0]  value,
  output logic                          done,
  output logic [STATUS_W-1:0]           status,
  output logic [COUNT_OUT_W-1:0]        entry_count,
  output logic                          evicted_valid,
  output logic signed [DATA_WIDTH-1:0]  evicted_value,
  input  logic                          cfg_wr_en,
  input  logic [CAP_W-1:0]              cfg_wr_data
);

  // index width for the memory, count width that can also hold the depth itself
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  // list kept as a ring: logical position j lives at (head + j) mod depth
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] j);
    logic [CW:0] s;
    s = {{(CW + 1 - IW){1'b0}}, h} + {1'b0, j};
    if (s >= (CW + 1)'(MAX_ENTRIES)) begin
      s = s - (CW + 1)'(MAX_ENTRIES);
    end
    return s[IW-1:0];
  endfunction

  // entry memory, one read and one write port, registered read data
  logic [DATA_WIDTH-1:0] mem [MAX_ENTRIES];
  logic [DATA_WIDTH-1:0] rdata;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic                  we;
  logic [IW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  state_t                state;
  logic [CAP_W-1:0]      capacity;
  logic [CW-1:0]         cap_eff;
  logic [CW-1:0]         count;
  logic [IW-1:0]         head;
  logic [MODE_W-1:0]     mode_q;
  logic [DATA_WIDTH-1:0] key_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CW-1:0]         pos;        // logical insert position
  logic [CW-1:0]         rd_j;       // logical index being read
  logic                  rd_active;  // tail move still has entries to read
  logic                  pend;       // read data waits to be written one place up
  logic [CW-1:0]         pend_j;
  logic                  cmp_vld;    // search compare stage holds a live entry
  logic [CW-1:0]         cmp_j;
  logic                  ev_vld;
  logic [DATA_WIDTH-1:0] ev_val;
  logic                  accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // capacity zero acts as one, above depth acts as the depth
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (32'(capacity) > MAX_ENTRIES) begin
      cap_eff = CW'(MAX_ENTRIES);
    end else begin
      cap_eff = CW'(capacity);
    end
  end

  // memory port steering
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    we      = 1'b0;
    wr_addr = head;
    wr_data = val_q;
    case (state)
      ST_IDLE: begin
        // delete reads its victim right at the transfer
        rd_en = accept;
        if (mode == MODE_DEL_END) begin
          rd_addr = phys(head, count - CW'(1));
        end
      end
      ST_SEARCH: begin
        rd_en   = 1'b1;
        rd_addr = phys(head, rd_j);
      end
      ST_PREP: begin
        // first entry is read, for use when the insert overflows
        rd_en = 1'b1;
      end
      ST_SHIFT: begin
        rd_en   = rd_active;
        rd_addr = phys(head, rd_j);
        if (pend) begin
          we      = 1'b1;
          wr_addr = phys(head, pend_j + CW'(1));
          wr_data = rdata;
        end else if (!rd_active) begin
          we      = 1'b1;
          wr_addr = phys(head, pos);
          wr_data = val_q;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      capacity      <= CAP_RESET;
      count         <= '0;
      head          <= '0;
      done          <= 1'b0;
      rd_active     <= 1'b0;
      pend          <= 1'b0;
      cmp_vld       <= 1'b0;
      ev_vld        <= 1'b0;
      status        <= STAT_OK;
      entry_count   <= '0;
      evicted_valid <= 1'b0;
      evicted_value <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            mode_q <= mode;
            key_q  <= key;
            val_q  <= value;
            ev_vld <= 1'b0;
            ev_val <= '0;
            case (mode)
              MODE_PUSH: begin
                pos   <= count;
                state <= ST_PREP;
              end
              MODE_AFTER, MODE_BEFORE: begin
                if (count == '0) begin
                  done          <= 1'b1;
                  status        <= STAT_NOT_FOUND;
                  entry_count   <= COUNT_OUT_W'(count);
                  evicted_valid <= 1'b0;
                  evicted_value <= '0;
                end else begin
                  rd_j    <= '0;
                  cmp_vld <= 1'b0;
                  state   <= ST_SEARCH;
                end
              end
              MODE_DEL_END, MODE_DEL_START: begin
                if (count == '0) begin
                  done          <= 1'b1;
                  status        <= STAT_EMPTY;
                  entry_count   <= COUNT_OUT_W'(count);
                  evicted_valid <= 1'b0;
                  evicted_value <= '0;
                end else begin
                  state <= ST_DELETE;
                end
              end
              default: begin
                // unused code: list untouched
                done          <= 1'b1;
                status        <= STAT_OK;
                entry_count   <= COUNT_OUT_W'(count);
                evicted_valid <= 1'b0;
                evicted_value <= '0;
              end
            endcase
          end
        end
        ST_SEARCH: begin
          // read issue and compare overlap, one entry per cycle
          if (rd_j < count) begin
            rd_j <= rd_j + CW'(1);
          end
          cmp_vld <= (rd_j < count);
          cmp_j   <= rd_j;
          if (cmp_vld && rdata == key_q) begin
            pos   <= cmp_j + CW'(mode_q == MODE_AFTER);
            state <= ST_PREP;
          end else if (cmp_vld && cmp_j == count - CW'(1)) begin
            done          <= 1'b1;
            status        <= STAT_NOT_FOUND;
            entry_count   <= COUNT_OUT_W'(count);
            evicted_valid <= 1'b0;
            evicted_value <= '0;
            state         <= ST_IDLE;
          end
        end
        ST_PREP: begin
          if (count >= cap_eff && !ev_vld) begin
            if (pos == '0) begin
              // new value would be first, so it is the one that leaves
              done          <= 1'b1;
              status        <= STAT_OK;
              entry_count   <= COUNT_OUT_W'(count);
              evicted_valid <= 1'b1;
              evicted_value <= val_q;
              state         <= ST_IDLE;
            end else begin
              state <= ST_EVICT;
            end
          end else begin
            rd_active <= (pos < count);
            rd_j      <= count - CW'(1);
            pend      <= 1'b0;
            state     <= ST_SHIFT;
          end
        end
        ST_EVICT: begin
          // drop the first entry by moving head, insert place moves down with it
          ev_vld <= 1'b1;
          ev_val <= rdata;
          head   <= phys(head, CW'(1));
          count  <= count - CW'(1);
          pos    <= pos - CW'(1);
          state  <= ST_PREP;
        end
        ST_SHIFT: begin
          // tail moves up from the last entry down to the insert place
          pend   <= rd_active;
          pend_j <= rd_j;
          if (rd_active) begin
            if (rd_j == pos) begin
              rd_active <= 1'b0;
            end else begin
              rd_j <= rd_j - CW'(1);
            end
          end
          if (!rd_active && !pend) begin
            count         <= count + CW'(1);
            done          <= 1'b1;
            status        <= STAT_OK;
            entry_count   <= COUNT_OUT_W'(count + CW'(1));
            evicted_valid <= ev_vld;
            evicted_value <= ev_val;
            state         <= ST_IDLE;
          end
        end
        ST_DELETE: begin
          if (mode_q == MODE_DEL_START) begin
            head <= phys(head, CW'(1));
          end
          count         <= count - CW'(1);
          done          <= 1'b1;
          status        <= STAT_OK;
          entry_count   <= COUNT_OUT_W'(count - CW'(1));
          evicted_valid <= 1'b1;
          evicted_value <= rdata;
          state         <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `BOLE_ASSERT(a_count_bound, count <= CW'(MAX_ENTRIES), "entry count above depth")
  `BOLE_IMPLY(a_done_idle, done, !busy, "result shown while still busy")
  `BOLE_NEXT(a_accept_moves, accept, busy || done, "accepted command made no progress")
  `BOLE_IMPLY(a_no_evict_zero, done && !evicted_valid, evicted_value == '0,
              "evicted value set without eviction")
  `BOLE_IMPLY(a_shift_in_range, state == ST_SHIFT && rd_active, rd_j < count,
              "tail move reads past the last entry")

endmodule

/* verif/bounded_ordered_list_engine_tb.sv */
`timescale 1ns / 100ps

module bounded_ordered_list_engine_tb;
  import bole_pkg::*;

  localparam int MAX_ENTRIES = 16;
  localparam int DATA_WIDTH  = 32;

  // modes the block ignores
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = 32'sh7fff_ffff;

  localparam int STALL_LIMIT    = 3000;
  localparam int TAIL_CYCLES    = 60;
  localparam int REPORT_LIMIT   = 10;
  localparam int ITEMS_PER_PHASE = 150;

  typedef struct packed {
    logic [STATUS_W-1:0]          status;
    logic [COUNT_OUT_W-1:0]       count;
    logic                         ev_valid;
    logic signed [DATA_WIDTH-1:0] ev_value;
  } list_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [MODE_W-1:0]             mode = '0;
  logic signed [DATA_WIDTH-1:0]  key = '0;
  logic signed [DATA_WIDTH-1:0]  value = '0;
  logic                          done;
  logic [STATUS_W-1:0]           status;
  logic [COUNT_OUT_W-1:0]        entry_count;
  logic                          evicted_valid;
  logic signed [DATA_WIDTH-1:0]  evicted_value;
  logic                          cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]              cfg_wr_data = '0;

  // shadow copy of the list, position 0 is the first entry
  logic signed [DATA_WIDTH-1:0] shadow_list[$];
  logic [CAP_W-1:0]             shadow_cap = CAP_RESET;

  // results owed by the block, oldest first
  list_result_t owed_results[$];

  int  mismatch_count = 0;
  int  stall_cycles   = 0;
  bit  gaps_on        = 1'b1;

  bounded_ordered_list_engine #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .DATA_WIDTH  (DATA_WIDTH)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .key           (key),
    .value         (value),
    .done          (done),
    .status        (status),
    .entry_count   (entry_count),
    .evicted_valid (evicted_valid),
    .evicted_value (evicted_value),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // apply one operation to the shadow list and return what the block should report
  function automatic list_result_t apply_list_op(input logic [MODE_W-1:0] m,
                                                 input logic signed [DATA_WIDTH-1:0] k,
                                                 input logic signed [DATA_WIDTH-1:0] v);
    list_result_t r;
    int lim;
    int hit;
    int pos;
    bit do_insert;
    r = '0;
    r.status = STAT_OK;
    do_insert = 1'b0;
    pos = 0;
    hit = -1;
    // zero behaves as one, anything above the store depth as the depth
    if (shadow_cap == 0) lim = 1;
    else if (shadow_cap > MAX_ENTRIES) lim = MAX_ENTRIES;
    else lim = shadow_cap;
    case (m)
      MODE_PUSH: begin
        pos = shadow_list.size();
        do_insert = 1'b1;
      end
      MODE_AFTER, MODE_BEFORE: begin
        // first matching entry wins
        for (int i = 0; i < shadow_list.size() && hit < 0; i++)
          if (shadow_list[i] == k) hit = i;
        if (hit < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          pos = (m == MODE_AFTER) ? hit + 1 : hit;
          do_insert = 1'b1;
        end
      end
      MODE_DEL_END, MODE_DEL_START: begin
        if (shadow_list.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.ev_valid = 1'b1;
          r.ev_value = (m == MODE_DEL_END) ? shadow_list.pop_back() : shadow_list.pop_front();
        end
      end
      default: ;
    endcase
    if (do_insert) begin
      if (pos >= shadow_list.size()) shadow_list.push_back(v);
      else shadow_list.insert(pos, v);
      // overflow drops the first entry, even when it is the one just placed
      if (shadow_list.size() > lim) begin
        r.ev_valid = 1'b1;
        r.ev_value = shadow_list.pop_front();
      end
    end
    r.count = COUNT_OUT_W'(shadow_list.size());
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // extremes, small values that collide, and full random words
  function automatic logic signed [DATA_WIDTH-1:0] pick_data();
    case ($urandom_range(0, 9))
      0:       return DATA_MIN;
      1:       return DATA_MAX;
      2, 3:    return DATA_WIDTH'($urandom_range(0, 7));
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  // drive one command and hold it until the transfer, then book its result
  task automatic send_cmd(input logic [MODE_W-1:0] m,
                          input logic signed [DATA_WIDTH-1:0] k,
                          input logic signed [DATA_WIDTH-1:0] v);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    mode  <= m;
    key   <= k;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    owed_results.push_back(apply_list_op(m, k, v));
  endtask

  // stop sending and let every owed result come back
  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (owed_results.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // capacity is only changed while the block is idle
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_for_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_cap = cap;
  endtask

  // random op; inserts mostly aim at a key that is in the list
  task automatic send_random_op(input int del_pct);
    int r;
    logic [MODE_W-1:0] m;
    logic signed [DATA_WIDTH-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      m = MODE_SPARE_FIRST + MODE_W'($urandom_range(0, MODE_SPARE_LAST - MODE_SPARE_FIRST));
    end else if (r < 3 + del_pct) begin
      m = $urandom_range(0, 1) ? MODE_DEL_END : MODE_DEL_START;
    end else begin
      case ($urandom_range(0, 2))
        0:       m = MODE_PUSH;
        1:       m = MODE_AFTER;
        default: m = MODE_BEFORE;
      endcase
    end
    if (shadow_list.size() != 0 && $urandom_range(0, 4) != 0)
      k = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    else
      k = pick_data();
    send_cmd(m, k, pick_data());
  endtask

  // deletes and inserts on an empty list, ignored modes, single-entry deletes
  task automatic test_empty_list_cases();
    send_cmd(MODE_DEL_END, '0, '0);
    send_cmd(MODE_DEL_START, DATA_MAX, DATA_MIN);
    send_cmd(MODE_AFTER, 32'sd0, 32'sd1);
    send_cmd(MODE_BEFORE, DATA_MIN, DATA_MAX);
    for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
      send_cmd(MODE_W'(m), pick_data(), pick_data());
    send_cmd(MODE_PUSH, '0, 32'sd42);
    send_cmd(MODE_DEL_END, '0, '0);
    send_cmd(MODE_PUSH, '0, 32'sd43);
    send_cmd(MODE_DEL_START, '0, '0);
  endtask

  // every operation with extreme data, head and tail inserts, duplicate keys
  task automatic test_directed_ops();
    send_cmd(MODE_PUSH, '0, DATA_MIN);
    send_cmd(MODE_PUSH, '0, DATA_MAX);
    send_cmd(MODE_PUSH, '0, 32'sd0);
    send_cmd(MODE_PUSH, '0, -32'sd1);
    send_cmd(MODE_AFTER, DATA_MAX, 32'sd5);
    send_cmd(MODE_BEFORE, DATA_MIN, 32'sd7);
    send_cmd(MODE_AFTER, -32'sd1, 32'sd9);
    send_cmd(MODE_BEFORE, 32'sd123, 32'sd8);
    send_cmd(MODE_PUSH, '0, 32'sd5);
    send_cmd(MODE_AFTER, 32'sd5, 32'sd11);
    send_cmd(MODE_DEL_END, '0, '0);
    send_cmd(MODE_DEL_START, '0, '0);
    // capacity far below the count, then an insert before the head
    set_capacity(5'd1);
    send_cmd(MODE_BEFORE, shadow_list[0], 32'sd77);
  endtask

  // random phases over a sweep of capacities, extremes and out-of-range values included
  task automatic test_capacity_sweep();
    logic [CAP_W-1:0] caps[12];
    int del_pcts[3];
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd16, 5'd5, 5'd10, 5'd3, 5'd8, 5'd16};
    del_pcts = '{15, 30, 50};
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      // every third phase runs back to back
      gaps_on = (p % 3) != 2;
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_random_op(del_pcts[p % 3]);
    end
    gaps_on = 1'b1;
  endtask

  // sender holds off until the block has answered everything, now and then
  task automatic test_drain_pause();
    set_capacity(5'd4);
    for (int i = 0; i < 120; i++) begin
      send_random_op(30);
      if (i % 8 == 7) wait_for_results();
    end
  endtask

  // result checker: one compare per done pulse against the oldest owed result
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && done === 1'b1) begin
      if (owed_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result at %0t: status %0d count %0d evicted %0b value %0d",
                   $time, status, entry_count, evicted_valid, evicted_value);
      end else begin
        want = owed_results.pop_front();
        if (status !== want.status || entry_count !== want.count ||
            evicted_valid !== want.ev_valid || evicted_value !== want.ev_value) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $write("mismatch at %0t (expected/actual): status %0d/%0d count %0d/%0d ",
                   $time, want.status, status, want.count, entry_count);
            $display("evicted %0b/%0b value %0d/%0d",
                     want.ev_valid, evicted_valid, want.ev_value, evicted_value);
          end
        end
      end
    end
  end

  // watchdog: any transfer in either direction counts as progress
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    // reset held at the start, released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list_cases();
    test_directed_ops();
    test_capacity_sweep();
    test_drain_pause();

    wait_for_results();
    // catch any stray result after the last one owed
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
